>>> rtl/lav_pkg.sv
// Shared constants for the look-at view matrix pipeline.
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

    // Stream field widths
    localparam int FIELD_W    = 32;
    localparam int AXIS_W     = 18;
    localparam int IN_DATA_W  = 9 * FIELD_W;
    localparam int OUT_DATA_W = 264;

    // Normaliser scaling: largest magnitude lands in [2^29, 2^30)
    localparam int NORM_W     = 30;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = 32;

endpackage
`default_nettype wire

>>> rtl/look_at_view_matrix_top.sv
// Top level: look-at view matrix pipeline with stream ports.
// Throughput: one camera beat per cycle while the output is not stalled; the two
// normalisers set the depth (one square-root bit and one quotient bit per stage).
// A stall on the output holds every stage in place.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [lav_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // right_x, right_y, right_z, right_shift, upvec_x, upvec_y, upvec_z,
    // upvec_shift, back_x, back_y, back_z, back_shift, zero pad
    output logic [lav_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import lav_pkg::*;

    localparam int OW   = FRAC_BITS + 2;
    localparam int PW   = FIELD_W + OW;
    localparam int CW   = PW + 1;
    localparam int YPW  = 2 * OW;
    localparam int DPW  = OW + FIELD_W;
    localparam int SW   = DPW + 2;
    localparam int ONE_I = 1 << FRAC_BITS;

    logic en;
    logic ov_reg;

    // Advance every stage unless the output beat is held
    assign en            = ~ov_reg | m_axis_tready;
    assign s_axis_tready = en;

    // Input register: eye minus target
    logic                         v1_reg;
    logic signed [FIELD_W:0]      d_reg   [3];
    logic signed [FIELD_W-1:0]    eye_reg [3];
    logic signed [FIELD_W-1:0]    up_reg  [3];
    logic signed [FIELD_W-1:0]    eye_in  [3];
    logic signed [FIELD_W-1:0]    tgt_in  [3];
    logic signed [FIELD_W-1:0]    up_in   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_in[i] = $signed(s_axis_tdata[FIELD_W*i +: FIELD_W]);
            tgt_in[i] = $signed(s_axis_tdata[FIELD_W*(3+i) +: FIELD_W]);
            up_in[i]  = $signed(s_axis_tdata[FIELD_W*(6+i) +: FIELD_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                d_reg[i] <= (FIELD_W+1)'(eye_in[i]) - (FIELD_W+1)'(tgt_in[i]);
            eye_reg <= eye_in;
            up_reg  <= up_in;
        end
    end

    // Backward axis z
    logic                   n1_valid;
    logic signed [OW-1:0]   z_n1 [3];
    logic [6*FIELD_W-1:0]   side1_in, side1_out;

    assign side1_in = {up_reg[2], up_reg[1], up_reg[0], eye_reg[2], eye_reg[1], eye_reg[0]};

    lav_norm #(
        .IN_W      (FIELD_W + 1),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (6 * FIELD_W)
    ) u_norm_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .vin       (d_reg),
        .side_in   (side1_in),
        .out_valid (n1_valid),
        .vout      (z_n1),
        .side_out  (side1_out)
    );

    // up cross z: partial products
    logic                      ca_v_reg;
    logic signed [PW-1:0]      ca_p_reg [6];
    logic signed [FIELD_W-1:0] ca_eye_reg [3];
    logic signed [FIELD_W-1:0] ca_up_c [3];
    logic signed [OW-1:0]      ca_z_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ca_up_c[i] = $signed(side1_out[FIELD_W*(3+i) +: FIELD_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ca_v_reg <= 1'b0;
        else if (en)
            ca_v_reg <= n1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_p_reg[0] <= ca_up_c[1] * z_n1[2];
            ca_p_reg[1] <= ca_up_c[2] * z_n1[1];
            ca_p_reg[2] <= ca_up_c[2] * z_n1[0];
            ca_p_reg[3] <= ca_up_c[0] * z_n1[2];
            ca_p_reg[4] <= ca_up_c[0] * z_n1[1];
            ca_p_reg[5] <= ca_up_c[1] * z_n1[0];
            for (int i = 0; i < 3; i++)
                ca_eye_reg[i] <= $signed(side1_out[FIELD_W*i +: FIELD_W]);
            ca_z_reg <= z_n1;
        end
    end

    // up cross z: differences
    logic                      cb_v_reg;
    logic signed [CW-1:0]      cb_c_reg [3];
    logic signed [FIELD_W-1:0] cb_eye_reg [3];
    logic signed [OW-1:0]      cb_z_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cb_v_reg <= 1'b0;
        else if (en)
            cb_v_reg <= ca_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                cb_c_reg[i] <= CW'(ca_p_reg[2*i]) - CW'(ca_p_reg[2*i+1]);
            cb_eye_reg <= ca_eye_reg;
            cb_z_reg   <= ca_z_reg;
        end
    end

    // Right axis x
    logic                          n2_valid;
    logic signed [OW-1:0]          x_n2 [3];
    logic [3*OW+3*FIELD_W-1:0]     side2_in, side2_out;

    assign side2_in = {cb_z_reg[2], cb_z_reg[1], cb_z_reg[0],
                       cb_eye_reg[2], cb_eye_reg[1], cb_eye_reg[0]};

    lav_norm #(
        .IN_W      (CW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (3 * OW + 3 * FIELD_W)
    ) u_norm_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cb_v_reg),
        .vin       (cb_c_reg),
        .side_in   (side2_in),
        .out_valid (n2_valid),
        .vout      (x_n2),
        .side_out  (side2_out)
    );

    // z cross x: partial products
    logic                      xa_v_reg;
    logic signed [YPW-1:0]     xa_p_reg [6];
    logic signed [FIELD_W-1:0] xa_eye_reg [3];
    logic signed [OW-1:0]      xa_z_c [3];
    logic signed [OW-1:0]      xa_z_reg [3];
    logic signed [OW-1:0]      xa_x_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            xa_z_c[i] = $signed(side2_out[3*FIELD_W + OW*i +: OW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xa_v_reg <= 1'b0;
        else if (en)
            xa_v_reg <= n2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_p_reg[0] <= xa_z_c[1] * x_n2[2];
            xa_p_reg[1] <= xa_z_c[2] * x_n2[1];
            xa_p_reg[2] <= xa_z_c[2] * x_n2[0];
            xa_p_reg[3] <= xa_z_c[0] * x_n2[2];
            xa_p_reg[4] <= xa_z_c[0] * x_n2[1];
            xa_p_reg[5] <= xa_z_c[1] * x_n2[0];
            for (int i = 0; i < 3; i++)
                xa_eye_reg[i] <= $signed(side2_out[FIELD_W*i +: FIELD_W]);
            xa_z_reg <= xa_z_c;
            xa_x_reg <= x_n2;
        end
    end

    // z cross x: differences
    logic                      xb_v_reg;
    logic signed [YPW:0]       xb_c_reg [3];
    logic signed [FIELD_W-1:0] xb_eye_reg [3];
    logic signed [OW-1:0]      xb_z_reg [3];
    logic signed [OW-1:0]      xb_x_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xb_v_reg <= 1'b0;
        else if (en)
            xb_v_reg <= xa_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                xb_c_reg[i] <= (YPW+1)'(xa_p_reg[2*i]) - (YPW+1)'(xa_p_reg[2*i+1]);
            xb_eye_reg <= xa_eye_reg;
            xb_z_reg   <= xa_z_reg;
            xb_x_reg   <= xa_x_reg;
        end
    end

    // Round and clamp the recomputed up axis y
    logic                      xc_v_reg;
    logic signed [OW-1:0]      xc_y_reg [3];
    logic signed [FIELD_W-1:0] xc_eye_reg [3];
    logic signed [OW-1:0]      xc_z_reg [3];
    logic signed [OW-1:0]      xc_x_reg [3];
    logic signed [OW-1:0]      y_next [3];

    always_comb
    begin
        logic [YPW:0] mag;
        logic [YPW:0] rnd;
        for (int i = 0; i < 3; i++)
        begin
            mag = xb_c_reg[i][YPW] ? (YPW+1)'(-xb_c_reg[i]) : (YPW+1)'(xb_c_reg[i]);
            rnd = (mag + ((YPW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (rnd > (YPW+1)'(ONE_I))
                rnd = (YPW+1)'(ONE_I);
            y_next[i] = xb_c_reg[i][YPW] ? -$signed(OW'(rnd)) : $signed(OW'(rnd));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xc_v_reg <= 1'b0;
        else if (en)
            xc_v_reg <= xb_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_y_reg   <= y_next;
            xc_eye_reg <= xb_eye_reg;
            xc_z_reg   <= xb_z_reg;
            xc_x_reg   <= xb_x_reg;
        end
    end

    // Translation: products of each axis with eye
    logic                  da_v_reg;
    logic signed [DPW-1:0] da_p_reg [3][3];
    logic signed [OW-1:0]  da_ax_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            da_v_reg <= 1'b0;
        else if (en)
            da_v_reg <= xc_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                da_p_reg[0][i] <= xc_x_reg[i] * xc_eye_reg[i];
                da_p_reg[1][i] <= xc_y_reg[i] * xc_eye_reg[i];
                da_p_reg[2][i] <= xc_z_reg[i] * xc_eye_reg[i];
            end
            da_ax_reg[0] <= xc_x_reg;
            da_ax_reg[1] <= xc_y_reg;
            da_ax_reg[2] <= xc_z_reg;
        end
    end

    // Translation: dot sums
    logic                 db_v_reg;
    logic signed [SW-1:0] db_s_reg [3];
    logic signed [OW-1:0] db_ax_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            db_v_reg <= 1'b0;
        else if (en)
            db_v_reg <= da_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                db_s_reg[r] <= SW'(da_p_reg[r][0]) + SW'(da_p_reg[r][1])
                             + SW'(da_p_reg[r][2]);
            db_ax_reg <= da_ax_reg;
        end
    end

    // Output register: round, negate and saturate each translation
    logic signed [FIELD_W-1:0] osh_reg [3];
    logic signed [OW-1:0]      oax_reg [3][3];
    logic signed [FIELD_W-1:0] sh_next [3];

    always_comb
    begin
        logic [SW-1:0]      mag;
        logic [SW-1:0]      rnd;
        logic signed [SW:0] neg;
        for (int r = 0; r < 3; r++)
        begin
            mag = db_s_reg[r][SW-1] ? SW'(-db_s_reg[r]) : SW'(db_s_reg[r]);
            rnd = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            neg = db_s_reg[r][SW-1] ? $signed({1'b0, rnd}) : -$signed({1'b0, rnd});
            if (neg > $signed((SW+1)'(32'h7FFF_FFFF)))
                sh_next[r] = 32'sh7FFF_FFFF;
            else if (neg < -$signed((SW+1)'(33'h0_8000_0000)))
                sh_next[r] = 32'sh8000_0000;
            else
                sh_next[r] = FIELD_W'(neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= db_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            osh_reg <= sh_next;
            oax_reg <= db_ax_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {
        6'b0,
        osh_reg[2], AXIS_W'(oax_reg[2][2]), AXIS_W'(oax_reg[2][1]), AXIS_W'(oax_reg[2][0]),
        osh_reg[1], AXIS_W'(oax_reg[1][2]), AXIS_W'(oax_reg[1][1]), AXIS_W'(oax_reg[1][0]),
        osh_reg[0], AXIS_W'(oax_reg[0][2]), AXIS_W'(oax_reg[0][1]), AXIS_W'(oax_reg[0][0])
    };

    // A zero backward axis leaves the right axis zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oax_reg[2][0] == '0 && oax_reg[2][1] == '0 && oax_reg[2][2] == '0)
        |-> (oax_reg[0][0] == '0 && oax_reg[0][1] == '0 && oax_reg[0][2] == '0))
    else $error("right axis not zero for zero backward axis");

    // A zero right axis leaves the up axis zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oax_reg[0][0] == '0 && oax_reg[0][1] == '0 && oax_reg[0][2] == '0)
        |-> (oax_reg[1][0] == '0 && oax_reg[1][1] == '0 && oax_reg[1][2] == '0))
    else $error("up axis not zero for zero right axis");

    // Normalised components right x and backward y stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (oax_reg[0][0] <= ONE_I && oax_reg[0][0] >= -ONE_I &&
                    oax_reg[2][1] <= ONE_I && oax_reg[2][1] >= -ONE_I))
    else $error("axis component beyond one");

    // A valid beat in the dot-sum stage reaches the output register when the pipe advances
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && db_v_reg) |=> ov_reg)
    else $error("output valid lost");

endmodule
`default_nettype wire

>>> rtl/lav_norm.sv
// Pipelined vector normaliser: scale, sum of squares, square root, divide.
`timescale 1ns / 1ps
`default_nettype none
module lav_norm #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [IN_W-1:0]      vin [3],
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] vout [3],
    output logic [SIDE_W-1:0]           side_out
);
    import lav_pkg::*;

    localparam int MW    = IN_W;
    localparam int OW    = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int NUMW  = NORM_W + FRAC_BITS + 1;
    localparam int CAR_W = SIDE_W + 4;   // {side, zero, neg[2:0]}
    localparam int SQ    = SQRT_STEPS;
    localparam int DV    = QW;

    // Stage 1: magnitudes and signs
    logic              v1_reg;
    logic [MW-1:0]     m1_reg [3];
    logic [CAR_W-1:0]  car1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m1_reg[i] <= vin[i][IN_W-1] ? MW'(-vin[i]) : MW'(vin[i]);
            car1_reg <= {side_in, 1'b0, vin[2][IN_W-1], vin[1][IN_W-1], vin[0][IN_W-1]};
        end
    end

    // Stage 2: locate the leading one of the largest magnitude
    logic              v2_reg;
    logic [6:0]        p2_reg;
    logic [MW-1:0]     m2_reg [3];
    logic [CAR_W-1:0]  car2_reg;
    logic [MW-1:0]     or_next;
    logic [6:0]        p_next;

    always_comb
    begin
        or_next = m1_reg[0] | m1_reg[1] | m1_reg[2];
        p_next  = 7'd0;
        for (int i = 0; i < MW; i++)
            if (or_next[i])
                p_next = 7'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg   <= p_next;
            m2_reg   <= m1_reg;
            car2_reg <= {car1_reg[CAR_W-1:4], (or_next == '0), car1_reg[2:0]};
        end
    end

    // Stage 3: scale into the fixed window
    logic              v3_reg;
    logic [NORM_W-1:0] ms3_reg [3];
    logic [CAR_W-1:0]  car3_reg;
    logic [NORM_W-1:0] ms_next [3];
    logic [63:0]       wide_c;

    always_comb
    begin
        wide_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (p2_reg >= 7'(NORM_W - 1))
                wide_c = 64'(m2_reg[i]) >> (p2_reg - 7'(NORM_W - 1));
            else
                wide_c = 64'(m2_reg[i]) << (7'(NORM_W - 1) - p2_reg);
            ms_next[i] = wide_c[NORM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ms3_reg  <= ms_next;
            car3_reg <= car2_reg;
        end
    end

    // Stage 4: squares
    logic                v4_reg;
    logic [2*NORM_W-1:0] sq4_reg [3];
    logic [NORM_W-1:0]   ms4_reg [3];
    logic [CAR_W-1:0]    car4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= ms3_reg[i] * ms3_reg[i];
            ms4_reg  <= ms3_reg;
            car4_reg <= car3_reg;
        end
    end

    // Stage 5 and square root: one result bit per stage
    logic              vq_reg   [0:SQ];
    logic [SUM_W:0]    rn_reg   [0:SQ];
    logic [SUM_W:0]    rt_reg   [0:SQ];
    logic [NORM_W-1:0] msq_reg  [0:SQ][3];
    logic [CAR_W-1:0]  carq_reg [0:SQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg[0] <= 1'b0;
        else if (en)
            vq_reg[0] <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn_reg[0]   <= (SUM_W+1)'(sq4_reg[0]) + (SUM_W+1)'(sq4_reg[1])
                         + (SUM_W+1)'(sq4_reg[2]);
            rt_reg[0]   <= '0;
            msq_reg[0]  <= ms4_reg;
            carq_reg[0] <= car4_reg;
        end
    end

    for (genvar k = 1; k <= SQ; k++)
    begin : g_sqrt
        localparam int SH = SUM_W - 2 * (k - 1);
        logic [SUM_W:0] one_c;
        logic [SUM_W:0] trial_c;

        assign one_c   = (SUM_W+1)'(1) << SH;
        assign trial_c = rt_reg[k-1] + one_c;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_reg[k] <= 1'b0;
            else if (en)
                vq_reg[k] <= vq_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rn_reg[k-1] >= trial_c)
                begin
                    rn_reg[k] <= rn_reg[k-1] - trial_c;
                    rt_reg[k] <= (rt_reg[k-1] >> 1) + one_c;
                end
                else
                begin
                    rn_reg[k] <= rn_reg[k-1];
                    rt_reg[k] <= rt_reg[k-1] >> 1;
                end
                msq_reg[k]  <= msq_reg[k-1];
                carq_reg[k] <= carq_reg[k-1];
            end
        end
    end

    // Divider set-up: numerator carries the half-divisor rounding term
    logic              vd_reg   [0:DV];
    logic [ROOT_W-1:0] dn_reg   [0:DV];
    logic [ROOT_W-1:0] rem_reg  [0:DV][3];
    logic [QW-1:0]     lo_reg   [0:DV][3];
    logic [QW-1:0]     q_reg    [0:DV][3];
    logic [CAR_W-1:0]  card_reg [0:DV];
    logic [ROOT_W-1:0] root_c;
    logic [NUMW-1:0]   num_c [3];

    assign root_c = rt_reg[SQ][ROOT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num_c[i] = {1'b0, msq_reg[SQ][i], FRAC_BITS'(0)} + NUMW'(root_c >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg[0] <= 1'b0;
        else if (en)
            vd_reg[0] <= vq_reg[SQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg[0] <= root_c;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= ROOT_W'(num_c[i][NUMW-1:QW]);
                lo_reg[0][i]  <= num_c[i][QW-1:0];
                q_reg[0][i]   <= '0;
            end
            card_reg[0] <= carq_reg[SQ];
        end
    end

    // Restoring division: one quotient bit per stage in each lane
    for (genvar j = 1; j <= DV; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[j] <= 1'b0;
            else if (en)
                vd_reg[j] <= vd_reg[j-1];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [ROOT_W:0] part_c;

            assign part_c = {rem_reg[j-1][l], lo_reg[j-1][l][QW-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (part_c >= {1'b0, dn_reg[j-1]})
                    begin
                        rem_reg[j][l] <= ROOT_W'(part_c - {1'b0, dn_reg[j-1]});
                        q_reg[j][l]   <= {q_reg[j-1][l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j][l] <= part_c[ROOT_W-1:0];
                        q_reg[j][l]   <= {q_reg[j-1][l][QW-2:0], 1'b0};
                    end
                    lo_reg[j][l] <= lo_reg[j-1][l] << 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dn_reg[j]   <= dn_reg[j-1];
                card_reg[j] <= card_reg[j-1];
            end
        end
    end

    // Output: apply signs, force zero-length vectors to zero
    logic                 vo_reg;
    logic signed [OW-1:0] vo_data_reg [3];
    logic [SIDE_W-1:0]    side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vd_reg[DV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (card_reg[DV][3])
                    vo_data_reg[i] <= '0;
                else if (card_reg[DV][i])
                    vo_data_reg[i] <= -$signed({1'b0, q_reg[DV][i]});
                else
                    vo_data_reg[i] <= $signed({1'b0, q_reg[DV][i]});
            end
            side_reg <= card_reg[DV][CAR_W-1:4];
        end
    end

    assign out_valid = vo_reg;
    assign vout      = vo_data_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire
